// ----- rtl/llag_pkg.sv -----
// Shared types and constants for the life-like automaton grid.
// Used by the interfaces, the sequencer, the row unit, the top level and the checker.
package llag_pkg;

    // Grid size
    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;

    // Derived widths
    localparam int ROW_AW = $clog2(GRID_HEIGHT);
    localparam int COL_AW = $clog2(GRID_WIDTH);
    localparam int STEP_W = $clog2(GRID_HEIGHT + 2);

    // Field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 6;
    localparam int MASK_W  = 9;
    localparam int CNT_W   = 4;

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = MASK_W;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIRTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SURVIVE = 1'd1;
    localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
    localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;

    typedef logic [GRID_WIDTH-1:0] row_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FETCH,
        ST_GEN,
        ST_CLEAR,
        ST_RESP
    } state_t;

    // Rule masks handed to the row unit
    typedef struct packed {
        logic [MASK_W-1:0] birth;
        logic [MASK_W-1:0] survive;
    } rule_t;

endpackage

// ----- rtl/llag_if.sv -----
// Valid/ready channel interfaces for command items and result items.
// Depends on llag_pkg for field widths.
interface llag_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [llag_pkg::CMD_W-1:0]  command;
    logic [llag_pkg::COORD_W-1:0] cell_x;
    logic [llag_pkg::COORD_W-1:0] cell_y;
    logic                        cell_value;

    modport source (output valid, command, cell_x, cell_y, cell_value, input ready);
    modport sink   (input valid, command, cell_x, cell_y, cell_value, output ready);
endinterface

interface llag_res_if;
    logic                       valid;
    logic                       ready;
    logic                       read_value;
    logic [llag_pkg::CMD_W-1:0] done_command;

    modport source (output valid, read_value, done_command, input ready);
    modport sink   (input valid, read_value, done_command, output ready);
endinterface

// ----- rtl/life_like_automaton_grid.sv -----
// Life-like automaton grid of GRID_WIDTH x GRID_HEIGHT one-bit cells (64 x 64 here),
// with birth/survival rule masks, cells beyond the edge counted as dead. After reset
// the block clears its row RAM and is not ready meanwhile.
// Items are taken one at a time: a cell write or read passes through a fetch state to the
// result register, a clear through a sweep that zeroes every row, and an advance
// through the sweep over the row RAM (one row read and one row written per cycle)
// through a single row-wide next-generation unit. The block is ready again in the
// cycle after the result is loaded; a previous result not yet taken delays the load
// of the next one. Rule masks are written through the cfg port; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Depends on llag_pkg, llag_if, llag_ram, llag_row_unit and llag_ctrl.
module life_like_automaton_grid (
    input  logic                            clk,
    input  logic                            rst_n,
    llag_cmd_if.sink                        cmd,
    llag_res_if.source                      res,
    input  logic                            cfg_we,
    input  logic [llag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [llag_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

    llag_pkg::rule_t                 rule_reg;
    logic                            ram_we;
    logic [llag_pkg::ROW_AW-1:0]     ram_waddr;
    llag_pkg::row_t                  ram_wdata;
    logic [llag_pkg::ROW_AW-1:0]     ram_raddr;
    llag_pkg::row_t                  ram_rdata;
    llag_pkg::row_t                  win_prev;
    llag_pkg::row_t                  win_cur;
    llag_pkg::row_t                  win_next;
    llag_pkg::row_t                  win_new;

    // Rule mask registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg.birth   <= llag_pkg::BIRTH_RESET;
            rule_reg.survive <= llag_pkg::SURVIVE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == llag_pkg::CFG_IDX_BIRTH)
            begin
                rule_reg.birth <= cfg_wdata;
            end
            if (cfg_index == llag_pkg::CFG_IDX_SURVIVE)
            begin
                rule_reg.survive <= cfg_wdata;
            end
        end
    end

    // Grid storage, one row per entry
    llag_ram #(
        .WIDTH (llag_pkg::GRID_WIDTH),
        .DEPTH (llag_pkg::GRID_HEIGHT)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-generation unit shared by every row of the sweep
    llag_row_unit u_row_unit (
        .prev_row (win_prev),
        .cur_row  (win_cur),
        .next_row (win_next),
        .rule     (rule_reg),
        .new_row  (win_new)
    );

    // Sequencer
    llag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .win_prev  (win_prev),
        .win_cur   (win_cur),
        .win_next  (win_next),
        .win_new   (win_new)
    );

endmodule

// ----- rtl/llag_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module llag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/llag_row_unit.sv -----
// Next-generation logic for one full row from a three-row window.
// Depends on llag_pkg for row width and the rule struct.
module llag_row_unit (
    input  llag_pkg::row_t  prev_row,
    input  llag_pkg::row_t  cur_row,
    input  llag_pkg::row_t  next_row,
    input  llag_pkg::rule_t rule,
    output llag_pkg::row_t  new_row
);

    // Pad with dead cells on both sides so edge columns see zeros
    logic [llag_pkg::GRID_WIDTH+1:0] prev_pad;
    logic [llag_pkg::GRID_WIDTH+1:0] cur_pad;
    logic [llag_pkg::GRID_WIDTH+1:0] next_pad;

    assign prev_pad = {1'b0, prev_row, 1'b0};
    assign cur_pad  = {1'b0, cur_row,  1'b0};
    assign next_pad = {1'b0, next_row, 1'b0};

    // One lane per column: count eight neighbors, look up the rule
    for (genvar c = 0; c < llag_pkg::GRID_WIDTH; c++)
    begin : g_col
        logic [7:0]                  nbr;
        logic [llag_pkg::CNT_W-1:0]  count;

        assign nbr = {prev_pad[c+2], prev_pad[c+1], prev_pad[c],
                      cur_pad[c+2],                 cur_pad[c],
                      next_pad[c+2], next_pad[c+1], next_pad[c]};

        always_comb
        begin
            count = '0;
            for (int i = 0; i < 8; i++)
            begin
                count = count + llag_pkg::CNT_W'(nbr[i]);
            end
        end

        assign new_row[c] = cur_row[c] ? rule.survive[count] : rule.birth[count];
    end

endmodule

// ----- rtl/llag_ctrl.sv -----
// Command sequencer: cell access, generation sweep, clearing sweep, result register.
// Depends on llag_pkg and llag_if; drives the grid RAM and the row unit window.
module llag_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    llag_cmd_if.sink                   cmd,
    llag_res_if.source                 res,
    // grid RAM ports
    output logic                       ram_we,
    output logic [llag_pkg::ROW_AW-1:0] ram_waddr,
    output llag_pkg::row_t             ram_wdata,
    output logic [llag_pkg::ROW_AW-1:0] ram_raddr,
    input  llag_pkg::row_t             ram_rdata,
    // row unit window
    output llag_pkg::row_t             win_prev,
    output llag_pkg::row_t             win_cur,
    output llag_pkg::row_t             win_next,
    input  llag_pkg::row_t             win_new
);

    llag_pkg::state_t                state_reg, state_next;
    logic [llag_pkg::STEP_W-1:0]     step_reg, step_next;
    llag_pkg::cmd_t                  cmd_reg;
    logic [llag_pkg::COORD_W-1:0]    x_reg;
    logic [llag_pkg::COORD_W-1:0]    y_reg;
    logic                            val_reg;
    logic                            inside_reg;
    logic                            rd_bit_reg;
    llag_pkg::row_t                  prev_row_reg;
    llag_pkg::row_t                  cur_row_reg;
    logic                            out_valid_reg;
    logic                            out_bit_reg;
    logic [llag_pkg::CMD_W-1:0]      out_cmd_reg;

    logic                            accept;
    logic                            out_load;
    logic                            in_inside;
    logic                            sweep_last;
    logic                            gen_last;
    logic                            gen_has_row;
    logic [llag_pkg::STEP_W-1:0]     step_minus2;
    logic [llag_pkg::COL_AW-1:0]     col;

    assign accept      = cmd.valid && cmd.ready;
    assign out_load    = (state_reg == llag_pkg::ST_RESP) && (!out_valid_reg || res.ready);
    assign in_inside   = (int'(cmd.cell_x) < llag_pkg::GRID_WIDTH) &&
                         (int'(cmd.cell_y) < llag_pkg::GRID_HEIGHT);
    assign sweep_last  = (step_reg == llag_pkg::STEP_W'(llag_pkg::GRID_HEIGHT - 1));
    assign gen_last    = (step_reg == llag_pkg::STEP_W'(llag_pkg::GRID_HEIGHT + 1));
    // During the sweep, RAM data holds row step-1 while step-1 is inside the grid
    assign gen_has_row = (step_reg <= llag_pkg::STEP_W'(llag_pkg::GRID_HEIGHT));
    assign step_minus2 = step_reg - llag_pkg::STEP_W'(2);
    assign col         = llag_pkg::COL_AW'(x_reg);

    // Window feeding the row unit
    assign win_prev = prev_row_reg;
    assign win_cur  = cur_row_reg;
    assign win_next = gen_has_row ? ram_rdata : '0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            llag_pkg::ST_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = llag_pkg::ST_IDLE;
                end
            end
            llag_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (llag_pkg::cmd_t'(cmd.command))
                        llag_pkg::CMD_ADVANCE: state_next = llag_pkg::ST_GEN;
                        llag_pkg::CMD_CLEAR:   state_next = llag_pkg::ST_CLEAR;
                        default:               state_next = llag_pkg::ST_FETCH;
                    endcase
                end
            end
            llag_pkg::ST_FETCH:
            begin
                state_next = llag_pkg::ST_RESP;
            end
            llag_pkg::ST_GEN:
            begin
                if (gen_last)
                begin
                    state_next = llag_pkg::ST_RESP;
                end
            end
            llag_pkg::ST_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = llag_pkg::ST_RESP;
                end
            end
            llag_pkg::ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = llag_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = llag_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: RAM control, ready, step counter
    always_comb
    begin
        cmd.ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = step_reg[llag_pkg::ROW_AW-1:0];
        ram_wdata = '0;
        ram_raddr = step_reg[llag_pkg::ROW_AW-1:0];
        step_next = '0;
        case (state_reg)
            llag_pkg::ST_INIT, llag_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                step_next = step_reg + llag_pkg::STEP_W'(1);
            end
            llag_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                ram_raddr = llag_pkg::ROW_AW'(cmd.cell_y);
            end
            llag_pkg::ST_FETCH:
            begin
                // read-modify-write of one cell
                ram_we    = (cmd_reg == llag_pkg::CMD_WRITE) && inside_reg;
                ram_waddr = llag_pkg::ROW_AW'(y_reg);
                ram_wdata = ram_rdata;
                ram_wdata[col] = val_reg;
            end
            llag_pkg::ST_GEN:
            begin
                ram_we    = (step_reg >= llag_pkg::STEP_W'(2));
                ram_waddr = step_minus2[llag_pkg::ROW_AW-1:0];
                ram_wdata = win_new;
                step_next = step_reg + llag_pkg::STEP_W'(1);
            end
            default:
            begin
                step_next = '0;
            end
        endcase
        if ((state_reg == llag_pkg::ST_INIT || state_reg == llag_pkg::ST_CLEAR) && sweep_last)
        begin
            step_next = '0;
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= llag_pkg::ST_INIT;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Item fields and sweep window
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= llag_pkg::cmd_t'(cmd.command);
            x_reg        <= cmd.cell_x;
            y_reg        <= cmd.cell_y;
            val_reg      <= cmd.cell_value;
            inside_reg   <= in_inside;
            rd_bit_reg   <= 1'b0;
            prev_row_reg <= '0;
            cur_row_reg  <= '0;
        end
        if (state_reg == llag_pkg::ST_FETCH && cmd_reg == llag_pkg::CMD_READ && inside_reg)
        begin
            rd_bit_reg <= ram_rdata[col];
        end
        if (state_reg == llag_pkg::ST_GEN && step_reg != '0)
        begin
            prev_row_reg <= cur_row_reg;
            cur_row_reg  <= win_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_bit_reg <= rd_bit_reg;
            out_cmd_reg <= cmd_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.read_value   = out_bit_reg;
    assign res.done_command = out_cmd_reg;

endmodule

// ----- rtl/llag_checker.sv -----
// Port-level checks for the automaton grid, bound to the top level.
// Depends on llag_pkg for command codes.
module llag_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       read_value,
    input logic [llag_pkg::CMD_W-1:0] done_command
);

    // A pending result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // One item at a time: no new item right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after an item was accepted");

    // Only a read returns a nonzero value
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (done_command != llag_pkg::CMD_READ) |-> !read_value)
        else $error("nonzero read_value on a non-read result");

    // A new result appears only when the block was busy the cycle before
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind life_like_automaton_grid llag_checker u_llag_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (cmd.valid),
    .in_ready     (cmd.ready),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .read_value   (res.read_value),
    .done_command (res.done_command)
);
